/* design/collinearity_point_projection_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the collinearity point projection block
// Implication checks, same cycle and next cycle, on a clock and an active-low
// reset.
// ----------------------------------------------------------------------------
`ifndef COLLINEARITY_POINT_PROJECTION_ASSERT_SVH
`define COLLINEARITY_POINT_PROJECTION_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define CPP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("colproj assertion failed");

// ante holds -> cons holds in the next cycle
`define CPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("colproj assertion failed");

`endif

/* design/colproj_pkg.sv */
// ----------------------------------------------------------------------------
// colproj_pkg
// Widths, register indexes, CORDIC constants and small arithmetic helpers.
// ----------------------------------------------------------------------------
package colproj_pkg;

    localparam int CAM_W     = 32;
    localparam int ANG_W     = 16;
    localparam int F_W       = 24;
    localparam int COEF_W    = 18;
    localparam int D_W       = 33;   // ground minus camera
    localparam int PROD_W    = 51;   // coeff * offset
    localparam int M_W       = 53;   // sum of three products
    localparam int N_W       = 85;   // f * |m| * 256
    localparam int QUOT_BITS = 40;   // quotient cap is 2^40
    localparam int DS_W      = M_W + QUOT_BITS;
    localparam int PIPE_LAT  = 9 + QUOT_BITS;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CAM_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PHI   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OMEGA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KAPPA = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL       = 3'd6;

    localparam logic [F_W-1:0] FOCAL_RESET = 24'd327680;

    localparam logic signed [31:0] PRINC_X = 32'sd10066;
    localparam logic signed [31:0] PRINC_Y = 32'sd10066;
    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    localparam int CORDIC_ITERS_DEF = 16;
    localparam int CORDIC_MAX       = 24;
    localparam int CX_W             = 20;
    localparam int CZ_W             = 28;
    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [CX_W-1:0] ONE_Q16     = 20'sd65536;
    localparam logic signed [16:0]     HALF_PI_U   = 17'sd12868;
    localparam logic signed [16:0]     PI_U        = 17'sd25736;
    localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd65536;

    function automatic logic signed [CZ_W-1:0] atan_val(input logic [4:0] idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            5'd0:  v = 28'sd13176795;
            5'd1:  v = 28'sd7778716;
            5'd2:  v = 28'sd4110060;
            5'd3:  v = 28'sd2086331;
            5'd4:  v = 28'sd1047214;
            5'd5:  v = 28'sd524117;
            5'd6:  v = 28'sd262123;
            5'd7:  v = 28'sd131069;
            5'd8:  v = 28'sd65536;
            5'd9:  v = 28'sd32768;
            5'd10: v = 28'sd16384;
            5'd11: v = 28'sd8192;
            5'd12: v = 28'sd4096;
            5'd13: v = 28'sd2048;
            5'd14: v = 28'sd1024;
            5'd15: v = 28'sd512;
            5'd16: v = 28'sd256;
            5'd17: v = 28'sd128;
            5'd18: v = 28'sd64;
            5'd19: v = 28'sd32;
            5'd20: v = 28'sd16;
            5'd21: v = 28'sd8;
            5'd22: v = 28'sd4;
            5'd23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q16 product, floor shift
    function automatic logic signed [19:0] mq(input logic signed [19:0] a,
                                              input logic signed [19:0] b);
        logic signed [39:0] p;
        p = a * b;
        return p[35:16];
    endfunction

    function automatic logic signed [COEF_W-1:0] clamp18(input logic signed [21:0] v);
        logic signed [COEF_W-1:0] r;
        if (v > 22'sd131071) begin
            r = 18'sd131071;
        end else if (v < -22'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[COEF_W-1:0];
        end
        return r;
    endfunction

    // {overflow, value}
    function automatic logic [32:0] sat32(input logic signed [44:0] v);
        logic [32:0] r;
        if (v > 45'(S32_MAX)) begin
            r = {1'b1, S32_MAX};
        end else if (v < 45'(S32_MIN)) begin
            r = {1'b1, S32_MIN};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

/* design/collinearity_point_projection.sv */
// ----------------------------------------------------------------------------
// collinearity_point_projection
// Projects ground points through the collinearity equations onto the image.
// ----------------------------------------------------------------------------
// Usage:
//  - A request is taken at a rising edge with start high and busy low. It
//    carries one ground point (mm) and its measured image coordinates.
//  - One result per request, shown for exactly one cycle with o_valid high.
//    o_valid comes from the last pipeline register, behind the divider and
//    post stages; the receiver cannot stall, so the pipeline never holds.
//  - Throughput: one request per cycle while busy is low, set by the fully
//    pipelined datapath: offset, nine multiplies, sums, magnitudes, split
//    focal multiply, a cap compare and a 40-stage restoring divider (one
//    quotient bit per stage).
//  - Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) land at once. An angle
//    write starts a rebuild of the rotation matrix: CORDIC_ITERS iterations of
//    three parallel CORDIC units, then two product steps. busy is high
//    during the rebuild.
//  - Reset (i_rst_n low, synchronous) empties the pipeline, loads the reset
//    register values and the exact identity matrix.
// ----------------------------------------------------------------------------
module collinearity_point_projection #(
    parameter int CORDIC_ITERS = colproj_pkg::CORDIC_ITERS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [31:0]                    i_ground_x,
    input  logic signed [31:0]                    i_ground_y,
    input  logic signed [31:0]                    i_ground_z,
    input  logic signed [31:0]                    i_measured_x,
    input  logic signed [31:0]                    i_measured_y,
    input  logic                                  i_cfg_we,
    input  logic [colproj_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [colproj_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                                  o_valid,
    output logic signed [31:0]                    o_projected_x,
    output logic signed [31:0]                    o_projected_y,
    output logic signed [31:0]                    o_residual_x,
    output logic signed [31:0]                    o_residual_y,
    output logic                                  o_zero_depth,
    output logic                                  o_overflow
);

    localparam int IT_W  = $clog2(CORDIC_ITERS);
    localparam int QB    = colproj_pkg::QUOT_BITS;
    localparam int N_W   = colproj_pkg::N_W;
    localparam int M_W   = colproj_pkg::M_W;
    localparam int D_W   = colproj_pkg::D_W;
    localparam int P_W   = colproj_pkg::PROD_W;
    localparam int DS_W  = colproj_pkg::DS_W;
    localparam int CX_W  = colproj_pkg::CX_W;
    localparam int CZ_W  = colproj_pkg::CZ_W;
    localparam int C_W   = colproj_pkg::COEF_W;
    localparam int LO_W  = 27;             // low slice of |m| for the split multiply
    localparam int HI_W  = M_W - LO_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0]                   r_cam [3];
    logic signed [colproj_pkg::ANG_W-1:0] r_ang [3];
    logic [colproj_pkg::F_W-1:0]          r_focal;
    logic                                 ang_hit [3];
    logic                                 ang_wr;
    logic signed [colproj_pkg::ANG_W-1:0] n_ang [3];

    always_comb begin
        ang_hit[0] = (i_cfg_idx == colproj_pkg::REG_ANGLE_PHI);
        ang_hit[1] = (i_cfg_idx == colproj_pkg::REG_ANGLE_OMEGA);
        ang_hit[2] = (i_cfg_idx == colproj_pkg::REG_ANGLE_KAPPA);
        ang_wr = i_cfg_we && (ang_hit[0] || ang_hit[1] || ang_hit[2]);
        for (int l = 0; l < 3; l++) begin
            n_ang[l] = (i_cfg_we && ang_hit[l]) ? i_cfg_data[colproj_pkg::ANG_W-1:0]
                                                : r_ang[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[0] <= '0;
            r_cam[1] <= '0;
            r_cam[2] <= '0;
            r_ang[0] <= '0;
            r_ang[1] <= '0;
            r_ang[2] <= '0;
            r_focal  <= colproj_pkg::FOCAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                colproj_pkg::REG_CAM_X:       r_cam[0] <= i_cfg_data;
                colproj_pkg::REG_CAM_Y:       r_cam[1] <= i_cfg_data;
                colproj_pkg::REG_CAM_Z:       r_cam[2] <= i_cfg_data;
                colproj_pkg::REG_ANGLE_PHI,
                colproj_pkg::REG_ANGLE_OMEGA,
                colproj_pkg::REG_ANGLE_KAPPA: r_ang <= n_ang;
                colproj_pkg::REG_FOCAL:       r_focal <= i_cfg_data[colproj_pkg::F_W-1:0];
                default: ;                    // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Rotation matrix rebuild: three CORDIC lanes (phi, omega, kappa),
    // then two product steps. Lanes 0..2 = phi, omega, kappa.
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {ST_IDLE, ST_ROT, ST_PROD, ST_COEF} t_state;

    t_state                     r_state;
    logic [IT_W-1:0]            r_iter;
    logic signed [CX_W-1:0]     r_cx [3];
    logic signed [CX_W-1:0]     r_cy [3];
    logic signed [CZ_W-1:0]     r_cz [3];
    logic                       r_neg [3];
    logic signed [C_W-1:0]      r_coef [9];
    // products of the first step
    logic signed [19:0]         r_ta, r_tb, r_pck, r_pcs, r_psc, r_pws, r_pwc;
    logic signed [19:0]         r_pthc, r_psk, r_pss;
    logic signed [C_W-1:0]      r_c [3];
    logic signed [C_W-1:0]      r_s [3];

    logic signed [16:0]         init_a [3];
    logic                       init_neg [3];
    logic signed [CZ_W-1:0]     init_z [3];
    logic signed [CX_W-1:0]     stp_x [3];
    logic signed [CX_W-1:0]     stp_y [3];
    logic signed [CZ_W-1:0]     stp_z [3];
    logic signed [CX_W-1:0]     cl_x [3];
    logic signed [CX_W-1:0]     cl_y [3];
    logic signed [CZ_W-1:0]     atan_i;
    logic signed [21:0]         v [9];

    always_comb begin
        atan_i = colproj_pkg::atan_val(5'(r_iter));
        for (int l = 0; l < 3; l++) begin
            // fold once by pi beyond +-pi/2
            init_a[l]   = 17'(n_ang[l]);
            init_neg[l] = 1'b0;
            if (init_a[l] > colproj_pkg::HALF_PI_U) begin
                init_a[l]   = init_a[l] - colproj_pkg::PI_U;
                init_neg[l] = 1'b1;
            end else if (init_a[l] < -colproj_pkg::HALF_PI_U) begin
                init_a[l]   = init_a[l] + colproj_pkg::PI_U;
                init_neg[l] = 1'b1;
            end
            init_z[l] = CZ_W'(init_a[l]) <<< 11;

            if (r_cz[l] >= 0) begin
                stp_x[l] = r_cx[l] - (r_cy[l] >>> r_iter);
                stp_y[l] = r_cy[l] + (r_cx[l] >>> r_iter);
                stp_z[l] = r_cz[l] - atan_i;
            end else begin
                stp_x[l] = r_cx[l] + (r_cy[l] >>> r_iter);
                stp_y[l] = r_cy[l] - (r_cx[l] >>> r_iter);
                stp_z[l] = r_cz[l] + atan_i;
            end

            cl_x[l] = r_cx[l];
            if (r_cx[l] > colproj_pkg::ONE_Q16)  cl_x[l] = colproj_pkg::ONE_Q16;
            if (r_cx[l] < -colproj_pkg::ONE_Q16) cl_x[l] = -colproj_pkg::ONE_Q16;
            cl_y[l] = r_cy[l];
            if (r_cy[l] > colproj_pkg::ONE_Q16)  cl_y[l] = colproj_pkg::ONE_Q16;
            if (r_cy[l] < -colproj_pkg::ONE_Q16) cl_y[l] = -colproj_pkg::ONE_Q16;
            if (r_neg[l]) begin
                cl_x[l] = -cl_x[l];
                cl_y[l] = -cl_y[l];
            end
        end

        // second product step and row sums
        v[0] = 22'(r_pck) - 22'(colproj_pkg::mq(r_ta, 20'(r_s[2])));
        v[1] = -22'(r_pcs) - 22'(colproj_pkg::mq(r_ta, 20'(r_c[2])));
        v[2] = -22'(r_psc);
        v[3] = 22'(r_pws);
        v[4] = 22'(r_pwc);
        v[5] = -22'(r_s[1]);
        v[6] = 22'(r_psk) + 22'(colproj_pkg::mq(r_tb, 20'(r_s[2])));
        v[7] = -22'(r_pss) + 22'(colproj_pkg::mq(r_tb, 20'(r_c[2])));
        v[8] = 22'(r_pthc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
            for (int k = 0; k < 9; k++) begin
                r_coef[k] <= (k % 4 == 0) ? colproj_pkg::COEF_ONE : '0;
            end
        end else if (ang_wr) begin
            // any angle write restarts the rebuild with the latest angles
            r_state <= ST_ROT;
            r_iter  <= '0;
            for (int l = 0; l < 3; l++) begin
                r_cx[l]  <= colproj_pkg::CORDIC_GAIN;
                r_cy[l]  <= '0;
                r_cz[l]  <= init_z[l];
                r_neg[l] <= init_neg[l];
            end
        end else begin
            case (r_state)
                ST_ROT: begin
                    for (int l = 0; l < 3; l++) begin
                        r_cx[l] <= stp_x[l];
                        r_cy[l] <= stp_y[l];
                        r_cz[l] <= stp_z[l];
                    end
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == IT_W'(CORDIC_ITERS - 1)) begin
                        r_state <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    // clamp and sign done on the fly; first products
                    for (int l = 0; l < 3; l++) begin
                        r_c[l] <= cl_x[l][C_W-1:0];
                        r_s[l] <= cl_y[l][C_W-1:0];
                    end
                    r_ta   <= colproj_pkg::mq(cl_y[0], cl_y[1]);
                    r_tb   <= colproj_pkg::mq(cl_x[0], cl_y[1]);
                    r_pck  <= colproj_pkg::mq(cl_x[0], cl_x[2]);
                    r_pcs  <= colproj_pkg::mq(cl_x[0], cl_y[2]);
                    r_psc  <= colproj_pkg::mq(cl_y[0], cl_x[1]);
                    r_pws  <= colproj_pkg::mq(cl_x[1], cl_y[2]);
                    r_pwc  <= colproj_pkg::mq(cl_x[1], cl_x[2]);
                    r_pthc <= colproj_pkg::mq(cl_x[0], cl_x[1]);
                    r_psk  <= colproj_pkg::mq(cl_y[0], cl_x[2]);
                    r_pss  <= colproj_pkg::mq(cl_y[0], cl_y[2]);
                    r_state <= ST_COEF;
                end
                ST_COEF: begin
                    for (int k = 0; k < 9; k++) begin
                        r_coef[k] <= colproj_pkg::clamp18(v[k]);
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy = (r_state != ST_IDLE);

    // ------------------------------------------------------------------
    // Stage 1: offsets from camera centre
    // ------------------------------------------------------------------
    logic                   accept;
    logic                   r1_v;
    logic signed [D_W-1:0]  r1_d [3];
    logic signed [31:0]     r1_mes_x, r1_mes_y;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= accept;
        r1_d[0]  <= D_W'(i_ground_x) - D_W'(r_cam[0]);
        r1_d[1]  <= D_W'(i_ground_y) - D_W'(r_cam[1]);
        r1_d[2]  <= D_W'(i_ground_z) - D_W'(r_cam[2]);
        r1_mes_x <= i_measured_x;
        r1_mes_y <= i_measured_y;
    end

    // ------------------------------------------------------------------
    // Stage 2: nine products; row k/3 of the offset times coefficient k
    // ------------------------------------------------------------------
    logic                   r2_v;
    logic signed [P_W-1:0]  r2_p [9];
    logic signed [31:0]     r2_mes_x, r2_mes_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        for (int k = 0; k < 9; k++) begin
            r2_p[k] <= P_W'(r_coef[k]) * P_W'(r1_d[k/3]);
        end
        r2_mes_x <= r1_mes_x;
        r2_mes_y <= r1_mes_y;
    end

    // ------------------------------------------------------------------
    // Stage 3: mX, mY, mZ
    // ------------------------------------------------------------------
    logic                   r3_v;
    logic signed [M_W-1:0]  r3_m [3];
    logic signed [31:0]     r3_mes_x, r3_mes_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        for (int c = 0; c < 3; c++) begin
            r3_m[c] <= M_W'(r2_p[c]) + M_W'(r2_p[c+3]) + M_W'(r2_p[c+6]);
        end
        r3_mes_x <= r2_mes_x;
        r3_mes_y <= r2_mes_y;
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitudes and quotient signs
    // ------------------------------------------------------------------
    logic                   r4_v;
    logic [M_W-1:0]         r4_ux, r4_uy, r4_ud;
    logic                   r4_neg_x, r4_neg_y, r4_zero;
    logic signed [31:0]     r4_mes_x, r4_mes_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        r4_ux    <= r3_m[0][M_W-1] ? M_W'(-r3_m[0]) : M_W'(r3_m[0]);
        r4_uy    <= r3_m[1][M_W-1] ? M_W'(-r3_m[1]) : M_W'(r3_m[1]);
        r4_ud    <= r3_m[2][M_W-1] ? M_W'(-r3_m[2]) : M_W'(r3_m[2]);
        r4_neg_x <= r3_m[0][M_W-1] ^ r3_m[2][M_W-1];
        r4_neg_y <= r3_m[1][M_W-1] ^ r3_m[2][M_W-1];
        r4_zero  <= (r3_m[2] == '0);
        r4_mes_x <= r3_mes_x;
        r4_mes_y <= r3_mes_y;
    end

    // ------------------------------------------------------------------
    // Stage 5: focal length times magnitude, split in two partial products
    // ------------------------------------------------------------------
    localparam int PL_W = colproj_pkg::F_W + LO_W;
    localparam int PH_W = colproj_pkg::F_W + HI_W;

    logic                   r5_v;
    logic [PL_W-1:0]        r5_lo_x, r5_lo_y;
    logic [PH_W-1:0]        r5_hi_x, r5_hi_y;
    logic [M_W-1:0]         r5_ud;
    logic                   r5_neg_x, r5_neg_y, r5_zero;
    logic signed [31:0]     r5_mes_x, r5_mes_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else          r5_v <= r4_v;
        r5_lo_x  <= PL_W'(r_focal) * PL_W'(r4_ux[LO_W-1:0]);
        r5_lo_y  <= PL_W'(r_focal) * PL_W'(r4_uy[LO_W-1:0]);
        r5_hi_x  <= PH_W'(r_focal) * PH_W'(r4_ux[M_W-1:LO_W]);
        r5_hi_y  <= PH_W'(r_focal) * PH_W'(r4_uy[M_W-1:LO_W]);
        r5_ud    <= r4_ud;
        r5_neg_x <= r4_neg_x;
        r5_neg_y <= r4_neg_y;
        r5_zero  <= r4_zero;
        r5_mes_x <= r4_mes_x;
        r5_mes_y <= r4_mes_y;
    end

    // ------------------------------------------------------------------
    // Stage 6: dividend f*|m|*256
    // ------------------------------------------------------------------
    logic                   r6_v;
    logic [N_W-1:0]         r6_nx, r6_ny;
    logic [M_W-1:0]         r6_ud;
    logic                   r6_neg_x, r6_neg_y, r6_zero;
    logic signed [31:0]     r6_mes_x, r6_mes_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else          r6_v <= r5_v;
        r6_nx    <= ((N_W'(r5_hi_x) << LO_W) + N_W'(r5_lo_x)) << 8;
        r6_ny    <= ((N_W'(r5_hi_y) << LO_W) + N_W'(r5_lo_y)) << 8;
        r6_ud    <= r5_ud;
        r6_neg_x <= r5_neg_x;
        r6_neg_y <= r5_neg_y;
        r6_zero  <= r5_zero;
        r6_mes_x <= r5_mes_x;
        r6_mes_y <= r5_mes_y;
    end

    // ------------------------------------------------------------------
    // Divider: cap check, then one quotient bit per stage, MSB first.
    // Without cap the dividend is below d*2^40, so 40 bits suffice.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [N_W-1:0]     rem_x;
        logic [N_W-1:0]     rem_y;
        logic [QB-1:0]      q_x;
        logic [QB-1:0]      q_y;
        logic               cap_x;
        logic               cap_y;
        logic [M_W-1:0]     d;
        logic               neg_x;
        logic               neg_y;
        logic               zero;
        logic signed [31:0] mes_x;
        logic signed [31:0] mes_y;
    } t_div;

    t_div r_div [0:QB];
    logic r_dv  [0:QB];
    logic [DS_W-1:0] dcap;

    assign dcap = DS_W'(r6_ud) << QB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else          r_dv[0] <= r6_v;
        r_div[0].rem_x <= r6_nx;
        r_div[0].rem_y <= r6_ny;
        r_div[0].q_x   <= '0;
        r_div[0].q_y   <= '0;
        r_div[0].cap_x <= (DS_W'(r6_nx) >= dcap);
        r_div[0].cap_y <= (DS_W'(r6_ny) >= dcap);
        r_div[0].d     <= r6_ud;
        r_div[0].neg_x <= r6_neg_x;
        r_div[0].neg_y <= r6_neg_y;
        r_div[0].zero  <= r6_zero;
        r_div[0].mes_x <= r6_mes_x;
        r_div[0].mes_y <= r6_mes_y;
    end

    for (genvar j = 1; j <= QB; j++) begin : g_div
        localparam int SH = QB - j;
        logic [DS_W-1:0] dsh;
        logic            ge_x, ge_y;
        t_div            n_div;

        assign dsh  = DS_W'(r_div[j-1].d) << SH;
        assign ge_x = DS_W'(r_div[j-1].rem_x) >= dsh;
        assign ge_y = DS_W'(r_div[j-1].rem_y) >= dsh;

        always_comb begin
            n_div       = r_div[j-1];
            n_div.rem_x = ge_x ? r_div[j-1].rem_x - dsh[N_W-1:0] : r_div[j-1].rem_x;
            n_div.rem_y = ge_y ? r_div[j-1].rem_y - dsh[N_W-1:0] : r_div[j-1].rem_y;
            n_div.q_x   = {r_div[j-1].q_x[QB-2:0], ge_x};
            n_div.q_y   = {r_div[j-1].q_y[QB-2:0], ge_y};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[j] <= 1'b0;
            else          r_dv[j] <= r_dv[j-1];
            r_div[j] <= n_div;
        end
    end

    // ------------------------------------------------------------------
    // Post stage 1: cap, sign, subtract from principal point
    // ------------------------------------------------------------------
    localparam int QF_W = QB + 1;
    localparam int SQ_W = QB + 2;
    localparam int PX_W = SQ_W + 2;
    localparam int RS_W = PX_W + 1;

    logic [QF_W-1:0]          qf_x, qf_y;
    logic signed [SQ_W-1:0]   sq_x, sq_y;
    logic                     rp_v;
    logic signed [PX_W-1:0]   rp_px, rp_py;
    logic signed [31:0]       rp_mes_x, rp_mes_y;
    logic                     rp_zero;

    always_comb begin
        qf_x = r_div[QB].cap_x ? (QF_W'(1) << QB) : QF_W'(r_div[QB].q_x);
        qf_y = r_div[QB].cap_y ? (QF_W'(1) << QB) : QF_W'(r_div[QB].q_y);
        sq_x = r_div[QB].neg_x ? -$signed({1'b0, qf_x}) : $signed({1'b0, qf_x});
        sq_y = r_div[QB].neg_y ? -$signed({1'b0, qf_y}) : $signed({1'b0, qf_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rp_v <= 1'b0;
        else          rp_v <= r_dv[QB];
        rp_px    <= PX_W'(colproj_pkg::PRINC_X) - PX_W'(sq_x);
        rp_py    <= PX_W'(colproj_pkg::PRINC_Y) - PX_W'(sq_y);
        rp_mes_x <= r_div[QB].mes_x;
        rp_mes_y <= r_div[QB].mes_y;
        rp_zero  <= r_div[QB].zero;
    end

    // ------------------------------------------------------------------
    // Post stage 2: residuals from the unsaturated projection, saturation
    // ------------------------------------------------------------------
    logic signed [RS_W-1:0] res_x, res_y;
    logic [32:0]            s_px, s_py, s_rx, s_ry;

    always_comb begin
        res_x = RS_W'(rp_mes_x) - RS_W'(rp_px);
        res_y = RS_W'(rp_mes_y) - RS_W'(rp_py);
        s_px  = colproj_pkg::sat32(45'(rp_px));
        s_py  = colproj_pkg::sat32(45'(rp_py));
        s_rx  = colproj_pkg::sat32(45'(res_x));
        s_ry  = colproj_pkg::sat32(45'(res_y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= rp_v;
        if (rp_zero) begin
            o_projected_x <= '0;
            o_projected_y <= '0;
            o_residual_x  <= '0;
            o_residual_y  <= '0;
            o_zero_depth  <= 1'b1;
            o_overflow    <= 1'b0;
        end else begin
            o_projected_x <= s_px[31:0];
            o_projected_y <= s_py[31:0];
            o_residual_x  <= s_rx[31:0];
            o_residual_y  <= s_ry[31:0];
            o_zero_depth  <= 1'b0;
            o_overflow    <= s_px[32] | s_py[32] | s_rx[32] | s_ry[32];
        end
    end

endmodule

/* design/colproj_checker.sv */
// ----------------------------------------------------------------------------
// colproj_checker
// Port-level checks for collinearity_point_projection, bound to the top level.
// ----------------------------------------------------------------------------
`include "collinearity_point_projection_assert.svh"

module colproj_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              i_cfg_we,
    input logic [colproj_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic                              o_valid,
    input logic signed [31:0]                o_projected_x,
    input logic signed [31:0]                o_projected_y,
    input logic signed [31:0]                o_residual_x,
    input logic signed [31:0]                o_residual_y,
    input logic                              o_zero_depth,
    input logic                              o_overflow
);

    // a result only where a request went in a fixed latency earlier
    `CPP_ASSERT_IMPL(a_lat, i_clk, i_rst_n, o_valid, $past(start && !busy, colproj_pkg::PIPE_LAT))

    // zero depth gives an all-zero result without overflow
    `CPP_ASSERT_IMPL(a_zero, i_clk, i_rst_n, o_valid && o_zero_depth, (o_projected_x == 0) && (o_projected_y == 0) && (o_residual_x == 0) && (o_residual_y == 0) && !o_overflow)

    // an angle write starts a matrix rebuild
    `CPP_ASSERT_NEXT(a_rebuild, i_clk, i_rst_n, i_cfg_we && ((i_cfg_idx == colproj_pkg::REG_ANGLE_PHI) || (i_cfg_idx == colproj_pkg::REG_ANGLE_OMEGA) || (i_cfg_idx == colproj_pkg::REG_ANGLE_KAPPA)), busy)

endmodule

bind collinearity_point_projection colproj_checker u_colproj_checker (.*);
